FILE: rtl/llhs_pkg.sv
package llhs_pkg;

  localparam int TIMER_BITS = 16;
  localparam int NUM_TIMERS = 7;

  typedef logic [TIMER_BITS-1:0] timer_t;
  localparam timer_t TMR_MAX = '1;

  localparam int T_ETH    = 0;
  localparam int T_LOCAL  = 1;
  localparam int T_REMOTE = 2;
  localparam int T_SLAC   = 3;
  localparam int T_SDP    = 4;
  localparam int T_TCP    = 5;
  localparam int T_APPL   = 6;

  typedef logic [2:0] req_t;
  localparam req_t REQ_TICK  = 3'd0;
  localparam req_t REQ_MODEM = 3'd1;
  localparam req_t REQ_SLAC  = 3'd2;
  localparam req_t REQ_SDP   = 3'd3;
  localparam req_t REQ_TCP   = 3'd4;
  localparam req_t REQ_APPL  = 3'd5;

  typedef logic [6:0] level_t;
  localparam level_t LVL_NONE   = 7'd0;
  localparam level_t LVL_ETH    = 7'd5;
  localparam level_t LVL_LOCAL  = 7'd10;
  localparam level_t LVL_SLAC   = 7'd15;
  localparam level_t LVL_REMOTE = 7'd20;
  localparam level_t LVL_SDP    = 7'd50;
  localparam level_t LVL_TCP    = 7'd80;
  localparam level_t LVL_APPL   = 7'd100;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SHORT_HOLD    = 3'd0;
  localparam cfg_idx_t CFG_REMOTE_HOLD   = 3'd1;
  localparam cfg_idx_t CFG_SLAC_HOLD     = 3'd2;
  localparam cfg_idx_t CFG_TICKS_PER_SEC = 3'd3;
  localparam cfg_idx_t CFG_ETH_ALWAYS_UP = 3'd4;

  typedef struct packed {
    logic [15:0] short_hold;
    logic [15:0] remote_modem_hold;
    logic [15:0] slac_hold;
    logic [7:0]  tps_eff;
    logic        eth_always_up;
  } cfg_t;

  function automatic timer_t sat_hold(input logic [31:0] v);
    timer_t r;
    if (v > 32'(TMR_MAX)) begin
      r = TMR_MAX;
    end else begin
      r = v[TIMER_BITS-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/llhs_timer_bank.sv
module llhs_timer_bank
  import llhs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  req_t       req,
  input  logic [2:0] modems,
  input  logic [7:0] secs,
  input  cfg_t       cfg,
  output level_t     lvl_nxt
);

  timer_t      timer_r   [NUM_TIMERS];
  timer_t      timer_nxt [NUM_TIMERS];
  timer_t      dec       [NUM_TIMERS];
  logic [15:0] appl_prod;

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      dec[i] = (timer_r[i] != '0) ? timer_r[i] - 1'b1 : timer_r[i];
    end
  end

  always_comb begin
    if (dec[T_APPL] != '0) begin
      lvl_nxt = LVL_APPL;
    end else if (dec[T_TCP] != '0) begin
      lvl_nxt = LVL_TCP;
    end else if (dec[T_SDP] != '0) begin
      lvl_nxt = LVL_SDP;
    end else if (dec[T_REMOTE] != '0) begin
      lvl_nxt = LVL_REMOTE;
    end else if (dec[T_SLAC] != '0) begin
      lvl_nxt = LVL_SLAC;
    end else if (dec[T_LOCAL] != '0) begin
      lvl_nxt = LVL_LOCAL;
    end else if (dec[T_ETH] != '0) begin
      lvl_nxt = LVL_ETH;
    end else begin
      lvl_nxt = LVL_NONE;
    end
  end

  assign appl_prod = 16'(secs) * 16'(cfg.tps_eff);

  always_comb begin
    timer_nxt = timer_r;
    case (req)
      REQ_TICK: begin
        timer_nxt = dec;
        if (cfg.eth_always_up) begin
          timer_nxt[T_ETH] = sat_hold(32'(cfg.short_hold));
        end
      end
      REQ_MODEM: begin
        if (modems >= 3'd1) begin
          timer_nxt[T_LOCAL] = sat_hold(32'(cfg.short_hold));
        end
        if (modems >= 3'd2) begin
          timer_nxt[T_REMOTE] = sat_hold(32'(cfg.remote_modem_hold));
        end
      end
      REQ_SLAC: begin
        timer_nxt[T_SLAC] = sat_hold(32'(cfg.slac_hold));
      end
      REQ_SDP: begin
        timer_nxt[T_SDP] = sat_hold(32'(cfg.short_hold));
      end
      REQ_TCP: begin
        timer_nxt[T_TCP] = sat_hold(32'(cfg.short_hold));
      end
      REQ_APPL: begin
        timer_nxt[T_APPL] = sat_hold(32'(appl_prod));
      end
      default: begin
        timer_nxt = timer_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        timer_r[i] <= '0;
      end
    end else if (step_en) begin
      timer_r <= timer_nxt;
    end
  end

endmodule

FILE: rtl/layered_link_health_supervisor.sv
// A result is registered in the output register in the cycle after its transaction is taken.
// Throughput: one transaction per cycle while in_stall is low; the timer bank updates in a single pass.
// A new transaction is taken while a waiting result is being drained in the same cycle.
// Reset (rst_n low, synchronous) clears all timers, the level and the second counter,
// empties the output register and restores the register defaults.
module layered_link_health_supervisor
  import llhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_modems_found,
  input  logic [7:0]  in_appl_timeout_s,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_conn_level,
  output logic        out_level_changed,
  output logic        out_second_mark,
  output logic        out_no_link,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] short_hold_r;
  logic [15:0] remote_hold_r;
  logic [15:0] slac_hold_r;
  logic [7:0]  tps_r;
  logic        eth_up_r;
  cfg_t        cfg;

  logic        accept;
  logic        is_tick;
  level_t      lvl_nxt;
  level_t      level_r;
  logic [7:0]  sec_cnt_r;
  logic [8:0]  sec_inc;
  logic        sec_wrap;
  logic        mark;

  logic        out_valid_r;
  level_t      out_level_r;
  logic        out_changed_r;
  logic        out_mark_r;
  logic        out_no_link_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_hold_r  <= 16'd165;
      remote_hold_r <= 16'd330;
      slac_hold_r   <= 16'd660;
      tps_r         <= 8'd33;
      eth_up_r      <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SHORT_HOLD:    short_hold_r  <= cfg_data;
        CFG_REMOTE_HOLD:   remote_hold_r <= cfg_data;
        CFG_SLAC_HOLD:     slac_hold_r   <= cfg_data;
        CFG_TICKS_PER_SEC: tps_r         <= cfg_data[7:0];
        CFG_ETH_ALWAYS_UP: eth_up_r      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.short_hold        = short_hold_r;
    cfg.remote_modem_hold = remote_hold_r;
    cfg.slac_hold         = slac_hold_r;
    cfg.tps_eff           = (tps_r == 8'd0) ? 8'd1 : tps_r;
    cfg.eth_always_up     = eth_up_r;
  end

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_tick  = (in_req_type == REQ_TICK);

  llhs_timer_bank u_timer_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .req     (in_req_type),
    .modems  (in_modems_found),
    .secs    (in_appl_timeout_s),
    .cfg     (cfg),
    .lvl_nxt (lvl_nxt)
  );

  assign sec_inc  = {1'b0, sec_cnt_r} + 9'd1;
  assign sec_wrap = sec_inc >= {1'b0, cfg.tps_eff};
  assign mark     = (sec_cnt_r == 8'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= LVL_NONE;
      sec_cnt_r <= 8'd0;
    end else if (accept && is_tick) begin
      level_r   <= lvl_nxt;
      sec_cnt_r <= sec_wrap ? 8'd0 : sec_inc[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_tick) begin
        out_level_r   <= lvl_nxt;
        out_changed_r <= (lvl_nxt != level_r);
        out_mark_r    <= mark;
        out_no_link_r <= mark && (lvl_nxt < LVL_ETH);
      end else begin
        out_level_r   <= level_r;
        out_changed_r <= 1'b0;
        out_mark_r    <= 1'b0;
        out_no_link_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_conn_level    = out_level_r;
  assign out_level_changed = out_changed_r;
  assign out_second_mark   = out_mark_r;
  assign out_no_link       = out_no_link_r;

  a_report_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_tick) |=> (!out_changed_r && !out_mark_r && !out_no_link_r))
    else $error("flags set on a report transaction");

  a_no_link_needs_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_no_link_r) |-> (out_mark_r && out_level_r == LVL_NONE))
    else $error("no_link without second mark or with live level");

  a_level_legal: assert property (@(posedge clk) disable iff (!rst_n)
    level_r == LVL_NONE || level_r == LVL_ETH || level_r == LVL_LOCAL ||
    level_r == LVL_SLAC || level_r == LVL_REMOTE || level_r == LVL_SDP ||
    level_r == LVL_TCP || level_r == LVL_APPL)
    else $error("illegal connection level");

  a_out_tracks_level: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_level_r == level_r))
    else $error("result level differs from stored level");

endmodule
